// ===== hdl/swec_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sliding-window error counter.
package swec_pkg;

   // Fixed widths of the beat fields.
   localparam int KIND_IN_W = 6;
   localparam int OUT_W     = 36;
   localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

   // Command queue between the front and back parts.
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = 2;
   localparam int CMDQ_CNT_W = 3;

   // One classified input beat.
   typedef struct packed {
      logic                 record;
      logic                 tick;
      logic                 in_range;
      logic [KIND_IN_W-1:0] kind;
   } cmd_type;

   // Status returned from the back part to the front part.
   typedef struct packed {
      logic init_done;
      logic cmd_take;
   } back_status_type;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_SUM,
      ST_CLEAR
   } state_type;

endpackage

// ===== hdl/swec_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module swec_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== hdl/swec_front.sv =====
`timescale 1ns / 1ps
// Front part: accepts input beats, checks the kind and queues commands.
module swec_front import swec_pkg::*; #(
   parameter int KINDS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic                 req_record,
   input  logic                 req_tick,
   input  logic [KIND_IN_W-1:0] req_error_kind,
   output logic                 req_full,
   output logic                 cmd_valid,
   output cmd_type              cmd,
   input  back_status_type      status
);

   cmd_type                cmd_q_ff [CMDQ_DEPTH];
   cmd_type                cmd_q_in;
   logic [CMDQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]  count_ff, count_in;
   logic                   push_ok;
   logic                   pop_ok;

   // Nothing is taken while the back part is still clearing the store.
   assign req_full  = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH)) || !status.init_done;
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = status.cmd_take;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = cmd_q_ff[rd_ptr_ff];

   always_comb begin
      cmd_q_in.record   = req_record;
      cmd_q_in.tick     = req_tick;
      cmd_q_in.in_range = (int'(req_error_kind) < KINDS);
      cmd_q_in.kind     = req_error_kind;
      wr_ptr_in = push_ok ? wr_ptr_ff + CMDQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + CMDQ_PTR_W'(1) : rd_ptr_ff;
      unique case ({push_ok, pop_ok})
         2'b10:   count_in = count_ff + CMDQ_CNT_W'(1);
         2'b01:   count_in = count_ff - CMDQ_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         cmd_q_ff[wr_ptr_ff] <= cmd_q_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CMDQ_CNT_W'(CMDQ_DEPTH))
      else $error("command queue count overflow");

   a_no_take_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop_ok |-> cmd_valid)
      else $error("command taken from an empty queue");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push_ok && !pop_ok) |=> count_ff == $past(count_ff) + CMDQ_CNT_W'(1))
      else $error("command queue count did not follow a push");

endmodule

// ===== hdl/swec_back.sv =====
`timescale 1ns / 1ps
// Back part: clears the store, updates counts, sums a kind and clears rows.
module swec_back import swec_pkg::*; #(
   parameter int SLOTS      = 16,
   parameter int KINDS      = 64,
   parameter int COUNT_BITS = 32,
   parameter int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   parameter int KIND_W     = (KINDS > 1) ? $clog2(KINDS) : 1,
   parameter int DEPTH      = SLOTS * (1 << KIND_W),
   parameter int RAM_AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  cmd_type               cmd,
   output back_status_type       status,
   output logic                  ram_wr_en,
   output logic [RAM_AW-1:0]     ram_wr_addr,
   output logic [COUNT_BITS-1:0] ram_wr_data,
   output logic                  ram_rd_en,
   output logic [RAM_AW-1:0]     ram_rd_addr,
   input  logic [COUNT_BITS-1:0] ram_rd_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [OUT_W-1:0]      rsp_window_count
);

   localparam int STEP_W = $clog2(SLOTS + 1);
   localparam int SUM_W  = ((COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W) + 1;
   localparam int FULL_W = SLOT_W + KIND_W;

   state_type            state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [KIND_W-1:0]    clr_ff, clr_in;
   logic [RAM_AW-1:0]    init_ff, init_in;
   logic [SLOT_W-1:0]    cur_ff, cur_in;
   cmd_type              cmd_ff, cmd_in;
   logic [OUT_W-1:0]     acc_ff, acc_in;
   logic                 res_valid_ff, res_valid_in;
   logic [OUT_W-1:0]     res_count_ff, res_count_in;

   logic [KIND_W-1:0]     kind;
   logic [SLOT_W-1:0]     next_slot;
   logic [STEP_W-1:0]     prev_step;
   logic [SLOT_W-1:0]     data_slot;
   logic                  bump;
   logic [COUNT_BITS-1:0] val_sel;
   logic [SUM_W-1:0]      sum_wide;
   logic [OUT_W-1:0]      acc_next;
   logic [FULL_W-1:0]     rd_full;
   logic [FULL_W-1:0]     wr_full;

   assign kind      = KIND_W'(cmd_ff.kind);
   assign next_slot = (cur_ff == SLOT_W'(SLOTS - 1)) ? '0 : cur_ff + SLOT_W'(1);
   assign prev_step = step_ff - STEP_W'(1);
   assign data_slot = prev_step[SLOT_W-1:0];

   // The read of each row comes back here; a recorded error is added on
   // the way through for the current row, unless it is full, and written straight back.
   assign bump     = cmd_ff.record && (data_slot == cur_ff) && !(&ram_rd_data);
   assign val_sel  = bump ? ram_rd_data + COUNT_BITS'(1) : ram_rd_data;
   assign sum_wide = SUM_W'(acc_ff) + SUM_W'(val_sel);
   assign acc_next = (sum_wide > SUM_W'(OUT_MAX)) ? OUT_MAX : sum_wide[OUT_W-1:0];

   assign rsp_empty        = !res_valid_ff;
   assign rsp_window_count = res_count_ff;
   assign ram_rd_addr      = rd_full[RAM_AW-1:0];

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      clr_in       = clr_ff;
      init_in      = init_ff;
      cur_in       = cur_ff;
      cmd_in       = cmd_ff;
      acc_in       = acc_ff;
      res_valid_in = res_valid_ff;
      res_count_in = res_count_ff;
      status.init_done = (state_ff != ST_INIT);
      status.cmd_take  = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      rd_full     = {step_ff[SLOT_W-1:0], kind};
      wr_full     = {cur_ff, clr_ff};
      ram_wr_addr = wr_full[RAM_AW-1:0];

      if (rsp_pop && res_valid_ff) begin
         res_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = init_ff;
            if (init_ff == RAM_AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               init_in = init_ff + RAM_AW'(1);
            end
         end
         ST_IDLE: begin
            if (cmd_valid && !res_valid_ff) begin
               status.cmd_take = 1'b1;
               cmd_in  = cmd;
               acc_in  = '0;
               step_in = '0;
               if (cmd.in_range) begin
                  state_in = ST_SUM;
               end else begin
                  res_valid_in = 1'b1;
                  res_count_in = '0;
                  if (cmd.tick) begin
                     cur_in   = next_slot;
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
               end
            end
         end
         ST_SUM: begin
            if (step_ff < STEP_W'(SLOTS)) begin
               ram_rd_en = 1'b1;
            end
            if (step_ff != '0) begin
               acc_in  = acc_next;
               wr_full = {data_slot, kind};
               ram_wr_addr = wr_full[RAM_AW-1:0];
               ram_wr_en   = bump;
               ram_wr_data = val_sel;
            end
            if (step_ff == STEP_W'(SLOTS)) begin
               res_valid_in = 1'b1;
               res_count_in = acc_next;
               if (cmd_ff.tick) begin
                  cur_in   = next_slot;
                  clr_in   = '0;
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            if (clr_ff == KIND_W'(KINDS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + KIND_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_ff      <= '0;
         cur_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         cur_ff       <= cur_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      clr_ff       <= clr_in;
      cmd_ff       <= cmd_in;
      acc_ff       <= acc_in;
      res_count_ff <= res_count_in;
   end

   a_result_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM && step_ff == STEP_W'(SLOTS)) |-> !res_valid_ff)
      else $error("result register overwritten before it was popped");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> step_ff <= STEP_W'(SLOTS))
      else $error("summing step ran past the last slot");

   a_init_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_INIT) |=> (state_ff != ST_INIT))
      else $error("clearing pass restarted without a reset");

endmodule

// ===== hdl/sliding_window_error_counter.sv =====
`timescale 1ns / 1ps
// Top level of the sliding-window error counter: front, back and count store.
// The back part takes up a new beat only after the last one is done, a pace set by
// the single read port of the store and the wait for the result register to empty; with a
// tick, the row clearing that follows overlaps the pop. After reset the whole store,
// SLOTS * 2^ceil(log2(KINDS)) entries (1024 by default), is swept clear with req_full high.
module sliding_window_error_counter import swec_pkg::*; #(
   parameter int SLOTS      = 16,
   parameter int KINDS      = 64,
   parameter int COUNT_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic                 req_record,
   input  logic                 req_tick,
   input  logic [KIND_IN_W-1:0] req_error_kind,
   output logic                 req_full,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [OUT_W-1:0]     rsp_window_count
);

   // Each row of the store holds one interval; a kind sits at the low
   // address bits, so the row for a slot starts at slot * 2^KIND_W.
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int KIND_W = (KINDS > 1) ? $clog2(KINDS) : 1;
   localparam int DEPTH  = SLOTS * (1 << KIND_W);
   localparam int RAM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                  cmd_valid;
   cmd_type               cmd;
   back_status_type       status;
   logic                  ram_wr_en;
   logic [RAM_AW-1:0]     ram_wr_addr;
   logic [COUNT_BITS-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [RAM_AW-1:0]     ram_rd_addr;
   logic [COUNT_BITS-1:0] ram_rd_data;

   // The front part takes each beat, flags a kind beyond the table and
   // holds up to four commands, so the source is not stalled while a long
   // sum or row clear is under way in the back part, until all four are waiting.
   swec_front #(
      .KINDS (KINDS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_record     (req_record),
      .req_tick       (req_tick),
      .req_error_kind (req_error_kind),
      .req_full       (req_full),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .status         (status)
   );

   // The back part walks the slots of one kind through the store, adds
   // the recorded error on the current row, saturates the total and
   // parks it in the result register; a tick then clears the next row.
   swec_back #(
      .SLOTS      (SLOTS),
      .KINDS      (KINDS),
      .COUNT_BITS (COUNT_BITS),
      .SLOT_W     (SLOT_W),
      .KIND_W     (KIND_W),
      .DEPTH      (DEPTH),
      .RAM_AW     (RAM_AW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .status           (status),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_window_count (rsp_window_count)
   );

   // Count store: one counter per slot and kind.
   swec_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (DEPTH),
      .AW    (RAM_AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sliding-window error counter.
module tb_top;
   import swec_pkg::*;

   // Block configuration, kept equal to the defaults of the instance below.
   localparam int N_SLOTS     = 16;
   localparam int N_KINDS     = 64;
   localparam int COUNT_WIDTH = 32;
   localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = {COUNT_WIDTH{1'b1}};

   localparam int CLK_PERIOD     = 20;
   localparam int RESET_CYCLES   = 8;
   localparam int RANDOM_BEATS   = 1200;
   localparam int BEATS_PER_RUN  = RANDOM_BEATS / 3;
   localparam int MAX_REPORTS    = 10;
   // The slowest item needs a sum over every slot plus the clearing of a whole row;
   // the tail below comfortably covers both.
   localparam int TAIL_CYCLES    = 200;
   // Bound on the whole run, including the clearing sweep that follows reset.
   localparam int TIMEOUT_CYCLES = 600_000;

   // Idling profile of both sides of the block.
   typedef enum logic [1:0] {
      PH_RX_SLOW,   // sender idles rarely, receiver idles often
      PH_TX_SLOW,   // sender idles often, receiver idles rarely
      PH_NO_IDLE    // neither side idles
   } idle_phase_t;

   // One input beat waiting to be offered to the block.
   typedef struct {
      bit                   record;
      bit                   tick;
      logic [KIND_IN_W-1:0] kind;
      idle_phase_t          phase;
      bit                   drain_first;  // hold the beat until nothing is outstanding
   } error_beat_t;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_push       = 1'b0;
   logic                 req_record     = 1'b0;
   logic                 req_tick       = 1'b0;
   logic [KIND_IN_W-1:0] req_error_kind = '0;
   logic                 req_full;
   logic                 rsp_empty;
   logic                 rsp_pop        = 1'b0;
   logic [OUT_W-1:0]     rsp_window_count;

   error_beat_t          pending_beats[$];
   logic [OUT_W-1:0]     expected_counts[$];
   int                   accepted_total = 0;
   int                   results_seen   = 0;
   int                   fail_count     = 0;
   idle_phase_t          phase_now      = PH_RX_SLOW;
   bit                   took_beat;
   logic [OUT_W-1:0]     wanted_count;

   // Our own copy of the counter rows and the pointer to the current interval.
   bit [COUNT_WIDTH-1:0] interval_counts[N_SLOTS][N_KINDS];
   int                   live_slot = 0;

   sliding_window_error_counter #(
      .SLOTS      (N_SLOTS),
      .KINDS      (N_KINDS),
      .COUNT_BITS (COUNT_WIDTH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_record       (req_record),
      .req_tick         (req_tick),
      .req_error_kind   (req_error_kind),
      .req_full         (req_full),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_window_count (rsp_window_count)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Applies one accepted beat to the local copy of the counters and returns the
   // window total that the block must report for it. The order matters: the
   // count goes up first, the total is taken next, and only then does a tick
   // move to the next interval and wipe it.
   function automatic logic [OUT_W-1:0] window_total(input bit rec, input bit tk,
                                                     input logic [KIND_IN_W-1:0] kind);
      logic [OUT_W+7:0] total;
      logic [OUT_W-1:0] answer;
      total  = '0;
      answer = '0;
      // A kind beyond the table is not counted and reports zero.
      if (int'(kind) < N_KINDS) begin
         if (rec && interval_counts[live_slot][kind] != COUNT_FULL) begin
            interval_counts[live_slot][kind] = interval_counts[live_slot][kind] + 1'b1;
         end
         for (int s = 0; s < N_SLOTS; s++) begin
            total = total + interval_counts[s][kind];
         end
         answer = (total > OUT_MAX) ? OUT_MAX : total[OUT_W-1:0];
      end
      if (tk) begin
         live_slot = (live_slot + 1) % N_SLOTS;
         for (int k = 0; k < N_KINDS; k++) begin
            interval_counts[live_slot][k] = '0;
         end
      end
      return answer;
   endfunction

   task automatic add_beat(input bit rec, input bit tk, input int kind,
                           input idle_phase_t ph, input bit drain);
      error_beat_t b;
      b.record      = rec;
      b.tick        = tk;
      b.kind        = kind[KIND_IN_W-1:0];
      b.phase       = ph;
      b.drain_first = drain;
      pending_beats.push_back(b);
   endtask

   // Driver. A beat counts as taken at an edge where push was high and full was
   // low; the prediction is made there from the values that were on the ports.
   // A beat that is offered stays on the ports until it is taken, and while push
   // is low the payload ports carry random junk.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         took_beat = req_push && !req_full;
         if (took_beat) begin
            expected_counts.push_back(window_total(req_record, req_tick, req_error_kind));
            void'(pending_beats.pop_front());
            accepted_total <= accepted_total + 1;
         end
         if (req_push && !took_beat) begin
            // The block is full; the same beat stays on offer.
            req_push <= 1'b1;
         end else if (pending_beats.size() != 0 &&
                      (!pending_beats[0].drain_first ||
                       accepted_total + int'(took_beat) == results_seen) &&
                      $urandom_range(99) >= ((pending_beats[0].phase == PH_RX_SLOW) ? 9 :
                                             (pending_beats[0].phase == PH_TX_SLOW) ? 61 : 0))
         begin
            req_push       <= 1'b1;
            req_record     <= pending_beats[0].record;
            req_tick       <= pending_beats[0].tick;
            req_error_kind <= pending_beats[0].kind;
            phase_now      <= pending_beats[0].phase;
         end else begin
            req_push       <= 1'b0;
            req_record     <= 1'($urandom);
            req_tick       <= 1'($urandom);
            req_error_kind <= KIND_IN_W'($urandom);
         end
      end
   end

   // Monitor. Every result taken is checked against the oldest prediction; pop
   // is withdrawn at random according to the idling profile of the beats that
   // are currently being offered.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_seen <= results_seen + 1;
            if (expected_counts.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("%0t: result with nothing outstanding, window_count %0d",
                           $realtime, rsp_window_count);
               end
            end else begin
               wanted_count = expected_counts.pop_front();
               if (rsp_window_count !== wanted_count) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS) begin
                     $display("%0t: window_count mismatch, expected %0d, got %0d",
                              $realtime, wanted_count, rsp_window_count);
                  end
               end
            end
         end
         rsp_pop <= $urandom_range(99) >= ((phase_now == PH_RX_SLOW) ? 61 :
                                           (phase_now == PH_TX_SLOW) ? 9 : 0);
      end
   end

   // Stimulus and end of run.
   initial begin
      int hot_kinds[4];
      int pick;
      idle_phase_t ph;

      // Directed opening: reads of an empty window at both ends of the kind
      // range, repeated records, a record together with a tick, and then a full
      // lap of ticks so that the interval pointer wraps and the first interval,
      // which still holds counts, is wiped when the pointer comes back to it.
      add_beat(1'b0, 1'b0, 0,  PH_RX_SLOW, 1'b1);
      add_beat(1'b0, 1'b0, 63, PH_RX_SLOW, 1'b0);
      add_beat(1'b1, 1'b0, 0,  PH_RX_SLOW, 1'b0);
      add_beat(1'b1, 1'b0, 0,  PH_RX_SLOW, 1'b0);
      add_beat(1'b1, 1'b0, 63, PH_RX_SLOW, 1'b0);
      add_beat(1'b1, 1'b1, 63, PH_RX_SLOW, 1'b0);
      add_beat(1'b1, 1'b0, 63, PH_RX_SLOW, 1'b0);
      add_beat(1'b1, 1'b0, 0,  PH_RX_SLOW, 1'b0);
      for (int i = 0; i < N_SLOTS - 1; i++) begin
         add_beat(1'b0, 1'b1, 63, PH_RX_SLOW, 1'b0);
      end
      add_beat(1'b0, 1'b0, 0,  PH_RX_SLOW, 1'b0);
      add_beat(1'b0, 1'b0, 63, PH_RX_SLOW, 1'b0);

      // Random part. Most beats hit a handful of busy kinds, including ones with
      // alternating bit patterns, so that totals build up across several
      // intervals before the ticks wipe them again; the rest are spread over the
      // whole range. The first beat of every idling profile, and a few others,
      // wait until the block has returned everything it owes.
      hot_kinds = '{0, 21, 42, 63};
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         ph = (i < BEATS_PER_RUN) ? PH_RX_SLOW :
              (i < 2 * BEATS_PER_RUN) ? PH_TX_SLOW : PH_NO_IDLE;
         if ($urandom_range(99) < 60) begin
            pick = hot_kinds[$urandom_range(3)];
         end else begin
            pick = $urandom_range(N_KINDS - 1);
         end
         add_beat($urandom_range(99) < 65, $urandom_range(9) == 0, pick, ph,
                  (i % BEATS_PER_RUN == 0) || ($urandom_range(99) == 0));
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Wait until every beat has gone in and every result has come back, then
      // give the block time to show any result it should not produce.
      while (pending_beats.size() != 0 || accepted_total != results_seen) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_counts.size() != 0) begin
         $display("%0d results were never delivered", expected_counts.size());
         fail_count += expected_counts.size();
      end
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== sliding_window_error_counter.f =====
hdl/swec_pkg.sv
hdl/swec_ram.sv
hdl/swec_front.sv
hdl/swec_back.sv
hdl/sliding_window_error_counter.sv
verif/tb_top.sv
